/* rtl/adf_pkg.sv */
`default_nettype none

package adf_pkg;

	localparam int SAMP_W     = 12;
	localparam int COEF_W     = 17;
	localparam int PROD_W     = SAMP_W + COEF_W + 1;
	localparam int TAB_W      = 32;
	localparam int TAB_IDX_W  = 5;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 6;
	localparam int MAX_TAPS   = 32;
	localparam int MIN_TAPS   = 2;
	localparam int NUM_RATES  = 4;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_FIELD_W = 3 * SAMP_W + 1 + CNT_W;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_RATE_SELECT = '0;

	localparam logic [SAMP_W-1:0] SAMP_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
	localparam logic [SAMP_W-1:0] SAMP_MIN = {1'b1, {(SAMP_W-1){1'b0}}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	typedef enum logic [1:0] {
		RATE_200HZ = 2'd0,
		RATE_100HZ = 2'd1,
		RATE_50HZ  = 2'd2,
		RATE_25HZ  = 2'd3
	} rate_t;

	localparam rate_t RATE_RESET = RATE_100HZ;

	typedef enum logic [1:0] {
		STEP_RAW0  = 2'd0,
		STEP_RAW1  = 2'd1,
		STEP_DUMP0 = 2'd2,
		STEP_DUMP1 = 2'd3
	} step_t;

	typedef struct packed {
		logic  wr;
		rate_t wr_rate;
		rate_t rate;
	} cfg_t;

	// samp is indexed [set][axis], coef is indexed [stage][tap].
	typedef struct packed {
		logic [1:0][2:0][SAMP_W-1:0] samp;
		logic [1:0][1:0][COEF_W-1:0] coef;
		logic [1:0]                  dump;
		logic                        batch_end;
		logic [CNT_W-1:0]            batch_cnt;
	} desc_t;

	localparam logic [IDX_W-1:0] TAB_LEN [NUM_RATES] = '{6'd32, 6'd16, 6'd8, 6'd4};

	localparam logic [COEF_W-1:0] COEF_TAB [NUM_RATES][TAB_W] = '{
		'{17'd10784, 17'd11252, 17'd11721, 17'd12189, 17'd12603, 17'd13017, 17'd13367,
		  17'd13718, 17'd13999, 17'd14280, 17'd14484, 17'd14689, 17'd14814, 17'd14939,
		  17'd14980, 17'd15022, 17'd14980, 17'd14939, 17'd14814, 17'd14689, 17'd14484,
		  17'd14280, 17'd13999, 17'd13718, 17'd13367, 17'd13017, 17'd12603, 17'd12189,
		  17'd11721, 17'd11252, 17'd10784, 17'd0},
		'{17'd22504, 17'd24378, 17'd26033, 17'd27436, 17'd28559, 17'd29378, 17'd29877,
		  17'd30044, 17'd29877, 17'd29378, 17'd28559, 17'd27436, 17'd26033, 17'd24378,
		  17'd22504, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		  17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
		'{17'd48756, 17'd54872, 17'd58756, 17'd60088, 17'd58756, 17'd54872, 17'd48756,
		  17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		  17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		  17'd0, 17'd0, 17'd0},
		'{17'd109744, 17'd120176, 17'd109744, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		  17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		  17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		  17'd0}
	};

	function automatic logic [COEF_W-1:0] coef(input rate_t r, input logic [TAB_IDX_W-1:0] i);
		return COEF_TAB[r][i];
	endfunction

	// Filter length: table length cut to MAX_TAPS, forced even and at least two.
	function automatic logic [IDX_W-1:0] filt_len(input rate_t r);
		logic [IDX_W-1:0] n;
		n = TAB_LEN[r];
		if (n > IDX_W'(MAX_TAPS)) n = IDX_W'(MAX_TAPS);
		n[0] = 1'b0;
		if (n < IDX_W'(MIN_TAPS)) n = IDX_W'(MIN_TAPS);
		return n;
	endfunction

	function automatic logic [IDX_W-1:0] half_len(input rate_t r);
		logic [IDX_W-1:0] n;
		n = filt_len(r);
		return {1'b0, n[IDX_W-1:1]};
	endfunction

endpackage

`default_nettype wire

/* rtl/accel_decimating_fir.sv */
// Decimating three-axis FIR in accumulate-and-dump form.
// Input stream (s_axis_*): one item carries two packed 3-axis sample sets in
// three 32-bit words; tlast marks the last item of a batch. Output stream
// (m_axis_*): each item yields raw set 0, raw set 1, then a filtered set from
// each of the two staggered stages that completes its length on this item,
// so 2 to 4 results; tlast marks the final one, tuser tells raw from filtered.
// An accepted item passes through its queue entry and the stage-1 registers
// before its first result reaches the output register, which takes one result
// per cycle while the receiver is ready; the next item is popped as the last
// result issues. A two-entry queue sits between the accepting front
// and the multiply-accumulate back end, so input is taken while results wait.
// A stalled receiver holds the output register and fills the queue; only
// then does s_axis_tready drop. Reset clears the filter sums, the batch
// count and the queue and selects the 100 Hz table. Writing rate_select over
// the APB port restarts both stages; write it only while the block is idle.
`default_nettype none

module accel_decimating_fir #(
	parameter int ACC_BITS  = 34,
	parameter int OUT_SHIFT = 19
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// tdata: word_a [31:0], word_b [63:32], word_c [95:64]; tlast: batch_end
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [adf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                               s_axis_tlast,
	// tdata: axis_x [11:0], axis_y [23:12], axis_z [35:24], batch_done [36],
	// batch_filtered_count [42:37], zero [47:43]; tuser: kind; tlast: last
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [adf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	output logic                                    m_axis_tuser,
	output logic                                    m_axis_tlast,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [adf_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [adf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [adf_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                    pready
);

	adf_pkg::rate_t rate_q;
	adf_pkg::cfg_t  cfg;
	logic           reg_hit;
	logic           rate_wr;
	logic           full, push, pop, q_valid;
	adf_pkg::desc_t push_desc, q_head;

	assign pready  = 1'b1;
	assign reg_hit = paddr[adf_pkg::APB_ADDR_W-1:2] == adf_pkg::REG_RATE_SELECT;
	assign rate_wr = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {{(adf_pkg::APB_DATA_W-2){1'b0}}, rate_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= adf_pkg::RATE_RESET;
		end else if (rate_wr) begin
			rate_q <= adf_pkg::rate_t'(pwdata[1:0]);
		end
	end

	assign cfg.wr      = rate_wr;
	assign cfg.wr_rate = adf_pkg::rate_t'(pwdata[1:0]);
	assign cfg.rate    = rate_q;

	adf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.full          (full),
		.push          (push),
		.push_desc     (push_desc)
	);

	adf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_valid),
		.full      (full)
	);

	adf_back #(
		.ACC_BITS  (ACC_BITS),
		.OUT_SHIFT (OUT_SHIFT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.clr           (rate_wr),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

/* rtl/adf_front.sv */
`default_nettype none

module adf_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire adf_pkg::cfg_t                      cfg,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [adf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                               s_axis_tlast,
	input  wire logic                               full,
	output logic                                    push,
	output adf_pkg::desc_t                          push_desc
);

	logic [adf_pkg::IDX_W-1:0] idx0_q, idx1_q;
	logic [adf_pkg::CNT_W-1:0] cnt_q;
	logic [adf_pkg::IDX_W-1:0] len;
	logic [adf_pkg::IDX_W-1:0] nx0, nx1;
	logic                      dump0, dump1;
	logic [adf_pkg::CNT_W:0]   cnt_sum;
	logic [adf_pkg::CNT_W-1:0] cnt_new;
	logic [31:0]               word_a, word_b, word_c;

	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;

	assign word_a = s_axis_tdata[31:0];
	assign word_b = s_axis_tdata[63:32];
	assign word_c = s_axis_tdata[95:64];

	always_comb begin
		len     = adf_pkg::filt_len(cfg.rate);
		nx0     = idx0_q + adf_pkg::IDX_W'(2);
		nx1     = idx1_q + adf_pkg::IDX_W'(2);
		dump0   = nx0 >= len;
		dump1   = nx1 >= len;
		cnt_sum = {1'b0, cnt_q} + (adf_pkg::CNT_W+1)'(dump0) + (adf_pkg::CNT_W+1)'(dump1);
		if (cnt_sum > {1'b0, adf_pkg::CNT_MAX}) begin
			cnt_new = adf_pkg::CNT_MAX;
		end else begin
			cnt_new = cnt_sum[adf_pkg::CNT_W-1:0];
		end

		// The axis tag nibbles above each sample are dropped.
		push_desc.samp[0][0] = word_a[11:0];
		push_desc.samp[0][1] = word_a[27:16];
		push_desc.samp[0][2] = word_b[11:0];
		push_desc.samp[1][0] = word_b[27:16];
		push_desc.samp[1][1] = word_c[11:0];
		push_desc.samp[1][2] = word_c[27:16];

		// Indices stay even and below the length, so the odd tap never runs off the table.
		push_desc.coef[0][0] = adf_pkg::coef(cfg.rate, idx0_q[adf_pkg::TAB_IDX_W-1:0]);
		push_desc.coef[0][1] = adf_pkg::coef(cfg.rate,
			idx0_q[adf_pkg::TAB_IDX_W-1:0] + adf_pkg::TAB_IDX_W'(1));
		push_desc.coef[1][0] = adf_pkg::coef(cfg.rate, idx1_q[adf_pkg::TAB_IDX_W-1:0]);
		push_desc.coef[1][1] = adf_pkg::coef(cfg.rate,
			idx1_q[adf_pkg::TAB_IDX_W-1:0] + adf_pkg::TAB_IDX_W'(1));

		push_desc.dump      = {dump1, dump0};
		push_desc.batch_end = s_axis_tlast;
		push_desc.batch_cnt = cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx0_q <= '0;
			idx1_q <= adf_pkg::half_len(adf_pkg::RATE_RESET);
			cnt_q  <= '0;
		end else if (cfg.wr) begin
			idx0_q <= '0;
			idx1_q <= adf_pkg::half_len(cfg.wr_rate);
		end else if (push) begin
			idx0_q <= dump0 ? '0 : nx0;
			idx1_q <= dump1 ? '0 : nx1;
			cnt_q  <= s_axis_tlast ? '0 : cnt_new;
		end
	end

endmodule

`default_nettype wire

/* rtl/adf_queue.sv */
`default_nettype none

module adf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire adf_pkg::desc_t push_desc,
	input  wire logic           pop,
	output adf_pkg::desc_t      head,
	output logic                not_empty,
	output logic                full
);

	adf_pkg::desc_t             entry_q [adf_pkg::QDEPTH];
	logic [adf_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [adf_pkg::QCNT_W-1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == adf_pkg::QCNT_W'(adf_pkg::QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + adf_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + adf_pkg::QPTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + adf_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - adf_pkg::QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= adf_pkg::QCNT_W'(adf_pkg::QDEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/adf_back.sv */
`default_nettype none

module adf_back #(
	parameter int ACC_BITS  = 34,
	parameter int OUT_SHIFT = 19
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              clr,
	input  wire logic                              q_valid,
	input  wire adf_pkg::desc_t                    q_head,
	output logic                                   pop,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [adf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tlast
);

	localparam int SW = adf_pkg::SAMP_W;

	logic                         work_valid_q;
	adf_pkg::step_t               step_q, step_d;
	logic                         final_step;
	logic                         out_free, issue;

	logic signed [adf_pkg::PROD_W-1:0] prod_d  [2][3][2];
	logic signed [adf_pkg::PROD_W-1:0] prod_s1 [2][3][2];
	logic [1:0][2:0][SW-1:0]           samp_s1;
	logic [1:0]                        dump_s1;
	logic                              bend_s1;
	logic [adf_pkg::CNT_W-1:0]         cnt_s1;

	logic signed [ACC_BITS-1:0] acc_q  [2][3];
	logic signed [ACC_BITS-1:0] hold_q [2][3];
	logic signed [ACC_BITS-1:0] sum_d  [2][3];

	logic                      res_kind;
	logic [SW-1:0]             res_x, res_y, res_z;

	logic                      m_valid_q;
	logic                      m_kind_q, m_last_q, m_bdone_q;
	logic [SW-1:0]             m_x_q, m_y_q, m_z_q;
	logic [adf_pkg::CNT_W-1:0] m_cnt_q;

	function automatic logic [SW-1:0] sat_out(input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] sh;
		sh = v >>> OUT_SHIFT;
		if ((&sh[ACC_BITS-1:SW-1]) || !(|sh[ACC_BITS-1:SW-1])) begin
			return sh[SW-1:0];
		end else if (sh[ACC_BITS-1]) begin
			return adf_pkg::SAMP_MIN;
		end else begin
			return adf_pkg::SAMP_MAX;
		end
	endfunction

	assign out_free = !m_valid_q || m_axis_tready;
	assign issue    = work_valid_q && out_free;
	assign pop      = q_valid && (!work_valid_q || (issue && final_step));

	// Twelve product lanes: stage, axis, tap. Tap t always pairs with sample set t.
	always_comb begin
		for (int st = 0; st < 2; st++) begin
			for (int a = 0; a < 3; a++) begin
				for (int t = 0; t < 2; t++) begin
					prod_d[st][a][t] = $signed({1'b0, q_head.coef[st][t]})
						* $signed(q_head.samp[t][a]);
				end
			end
		end
	end

	always_comb begin
		for (int st = 0; st < 2; st++) begin
			for (int a = 0; a < 3; a++) begin
				sum_d[st][a] = acc_q[st][a] + ACC_BITS'(prod_s1[st][a][0])
					+ ACC_BITS'(prod_s1[st][a][1]);
			end
		end
	end

	always_comb begin
		step_d     = step_q;
		final_step = 1'b0;
		unique case (step_q)
			adf_pkg::STEP_RAW0: begin
				step_d = adf_pkg::STEP_RAW1;
			end
			adf_pkg::STEP_RAW1: begin
				if (dump_s1[0]) begin
					step_d = adf_pkg::STEP_DUMP0;
				end else if (dump_s1[1]) begin
					step_d = adf_pkg::STEP_DUMP1;
				end else begin
					final_step = 1'b1;
				end
			end
			adf_pkg::STEP_DUMP0: begin
				if (dump_s1[1]) begin
					step_d = adf_pkg::STEP_DUMP1;
				end else begin
					final_step = 1'b1;
				end
			end
			adf_pkg::STEP_DUMP1: begin
				final_step = 1'b1;
			end
			default: begin
				step_d     = adf_pkg::STEP_RAW0;
				final_step = 1'b1;
			end
		endcase
	end

	always_comb begin
		unique case (step_q)
			adf_pkg::STEP_RAW0: begin
				res_kind = 1'b0;
				res_x    = samp_s1[0][0];
				res_y    = samp_s1[0][1];
				res_z    = samp_s1[0][2];
			end
			adf_pkg::STEP_RAW1: begin
				res_kind = 1'b0;
				res_x    = samp_s1[1][0];
				res_y    = samp_s1[1][1];
				res_z    = samp_s1[1][2];
			end
			adf_pkg::STEP_DUMP0: begin
				res_kind = 1'b1;
				res_x    = sat_out(hold_q[0][0]);
				res_y    = sat_out(hold_q[0][1]);
				res_z    = sat_out(hold_q[0][2]);
			end
			adf_pkg::STEP_DUMP1: begin
				res_kind = 1'b1;
				res_x    = sat_out(hold_q[1][0]);
				res_y    = sat_out(hold_q[1][1]);
				res_z    = sat_out(hold_q[1][2]);
			end
			default: begin
				res_kind = 1'b0;
				res_x    = '0;
				res_y    = '0;
				res_z    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			step_q       <= adf_pkg::STEP_RAW0;
		end else if (pop) begin
			work_valid_q <= 1'b1;
			step_q       <= adf_pkg::STEP_RAW0;
		end else if (issue) begin
			if (final_step) begin
				work_valid_q <= 1'b0;
			end else begin
				step_q <= step_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= prod_d;
			samp_s1 <= q_head.samp;
			dump_s1 <= q_head.dump;
			bend_s1 <= q_head.batch_end;
			cnt_s1  <= q_head.batch_cnt;
		end
	end

	// Sums are folded in while the first raw set leaves; a dumping stage parks
	// its total in the hold register and starts over from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st < 2; st++) begin
				for (int a = 0; a < 3; a++) acc_q[st][a] <= '0;
			end
		end else if (clr) begin
			for (int st = 0; st < 2; st++) begin
				for (int a = 0; a < 3; a++) acc_q[st][a] <= '0;
			end
		end else if (issue && step_q == adf_pkg::STEP_RAW0) begin
			for (int st = 0; st < 2; st++) begin
				for (int a = 0; a < 3; a++) acc_q[st][a] <= dump_s1[st] ? '0 : sum_d[st][a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue && step_q == adf_pkg::STEP_RAW0) begin
			for (int st = 0; st < 2; st++) begin
				if (dump_s1[st]) begin
					for (int a = 0; a < 3; a++) hold_q[st][a] <= sum_d[st][a];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (issue) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			m_kind_q  <= res_kind;
			m_x_q     <= res_x;
			m_y_q     <= res_y;
			m_z_q     <= res_z;
			m_last_q  <= final_step;
			m_bdone_q <= final_step && bend_s1;
			m_cnt_q   <= (final_step && bend_s1) ? cnt_s1 : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {{adf_pkg::OUT_PAD_W{1'b0}}, m_cnt_q, m_bdone_q, m_z_q, m_y_q, m_x_q};

	a_dump0_flag: assert property (@(posedge clk) disable iff (!arst_n)
		issue && step_q == adf_pkg::STEP_DUMP0 |-> dump_s1[0])
		else $error("stage 0 result issued without a dump");
	a_dump1_flag: assert property (@(posedge clk) disable iff (!arst_n)
		issue && step_q == adf_pkg::STEP_DUMP1 |-> dump_s1[1])
		else $error("stage 1 result issued without a dump");
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		issue && step_q == adf_pkg::STEP_RAW0 && dump_s1[0] |=> acc_q[0][0] == '0)
		else $error("stage 0 sum not cleared after dump");
	a_work_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(work_valid_q) |-> $past(issue && final_step))
		else $error("item dropped before its last result");

endmodule

`default_nettype wire
